// ===== hdl/pqls_pkg.sv =====
package pqls_pkg;

  localparam int VALUE_W = 32;
  localparam int PRIO_W  = 16;
  localparam int CAP_W   = 5;
  localparam int COUNT_W = 5;
  localparam int STAT_W  = 2;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic OP_ADD     = 1'b0;
  localparam logic OP_EXTRACT = 1'b1;

  localparam logic [STAT_W-1:0] ST_ADDED     = 2'd0;
  localparam logic [STAT_W-1:0] ST_DROPPED   = 2'd1;
  localparam logic [STAT_W-1:0] ST_EXTRACTED = 2'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd3;

  localparam logic signed [VALUE_W-1:0] EMPTY_VALUE = -32'sd1;
  localparam logic signed [VALUE_W-1:0] ZERO_VALUE  = 32'sd0;

  typedef struct packed {
    logic                      op;
    logic signed [VALUE_W-1:0] item_value;
    logic signed [PRIO_W-1:0]  item_priority;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] out_value;
    logic [STAT_W-1:0]         status;
    logic [COUNT_W-1:0]        entry_count;
    logic                      is_full;
    logic                      is_empty;
  } out_item_t;

  // One stored queue entry: value and priority share a memory word.
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic signed [PRIO_W-1:0]  prio;
  } entry_t;

endpackage

// ===== hdl/pqls_mem.sv =====
module pqls_mem #(
  parameter int DEPTH = 16,
  parameter int IDX_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [IDX_W-1:0]  wr_addr,
  input  pqls_pkg::entry_t  wr_data,
  input  logic              rd_en,
  input  logic [IDX_W-1:0]  rd_addr,
  output pqls_pkg::entry_t  rd_data
);
  import pqls_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/pqls_ctrl.sv =====
module pqls_ctrl #(
  parameter int DEPTH = 16,
  parameter int IDX_W = $clog2(DEPTH),
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  pqls_pkg::in_item_t  in_data,
  input  logic [CNT_W-1:0]    cap_eff,
  output logic                res_valid,
  input  logic                res_ready,
  output pqls_pkg::out_item_t res_data,
  output logic                wr_en,
  output logic [IDX_W-1:0]    wr_addr,
  output pqls_pkg::entry_t    wr_data,
  output logic                rd_en,
  output logic [IDX_W-1:0]    rd_addr,
  input  pqls_pkg::entry_t    rd_data
);
  import pqls_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]                state_r, state_nxt;
  logic [CNT_W-1:0]          occ_r, occ_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic                      rvld_r, rvld_nxt;
  logic [IDX_W-1:0]          raddr_r, raddr_nxt;
  logic [IDX_W-1:0]          best_idx_r, best_idx_nxt;
  logic signed [PRIO_W-1:0]  best_prio_r, best_prio_nxt;
  logic signed [VALUE_W-1:0] res_val_r, res_val_nxt;
  logic [STAT_W-1:0]         res_st_r, res_st_nxt;

  logic             take;
  logic             last;
  logic             issue;
  logic [IDX_W-1:0] bidx;
  logic [CNT_W-1:0] shift_start;
  logic             in_acc;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  // The first entry read always seeds the running best; later ones win only
  // on a strictly larger priority, so the earliest entry keeps a tie.
  assign take  = rvld_r && ((raddr_r == '0) || (rd_data.prio > best_prio_r));
  assign last  = rvld_r && (CNT_W'(raddr_r) == occ_r - CNT_W'(1));
  assign issue = (cnt_r < occ_r);
  assign bidx  = take ? raddr_r : best_idx_r;
  assign shift_start = CNT_W'(bidx) + CNT_W'(1);

  always_comb begin
    state_nxt     = state_r;
    occ_nxt       = occ_r;
    cnt_nxt       = cnt_r;
    rvld_nxt      = 1'b0;
    raddr_nxt     = cnt_r[IDX_W-1:0];
    best_idx_nxt  = best_idx_r;
    best_prio_nxt = best_prio_r;
    res_val_nxt   = res_val_r;
    res_st_nxt    = res_st_r;
    rd_en         = 1'b0;
    rd_addr       = cnt_r[IDX_W-1:0];
    wr_en         = 1'b0;
    wr_addr       = occ_r[IDX_W-1:0];
    wr_data.value = in_data.item_value;
    wr_data.prio  = in_data.item_priority;
    res_valid     = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_data.op == OP_ADD) begin
            res_val_nxt = ZERO_VALUE;
            state_nxt   = S_DONE;
            if (occ_r >= cap_eff) begin
              res_st_nxt = ST_DROPPED;
            end else begin
              wr_en      = 1'b1;
              occ_nxt    = occ_r + CNT_W'(1);
              res_st_nxt = ST_ADDED;
            end
          end else if (occ_r == '0) begin
            res_val_nxt = EMPTY_VALUE;
            res_st_nxt  = ST_EMPTY;
            state_nxt   = S_DONE;
          end else begin
            cnt_nxt    = '0;
            res_st_nxt = ST_EXTRACTED;
            state_nxt  = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (issue) begin
          rd_en    = 1'b1;
          rvld_nxt = 1'b1;
          cnt_nxt  = cnt_r + CNT_W'(1);
        end
        if (take) begin
          best_idx_nxt  = raddr_r;
          best_prio_nxt = rd_data.prio;
          res_val_nxt   = rd_data.value;
        end
        if (last) begin
          if (shift_start < occ_r) begin
            cnt_nxt   = shift_start;
            state_nxt = S_SHIFT;
          end else begin
            occ_nxt   = occ_r - CNT_W'(1);
            state_nxt = S_DONE;
          end
        end
      end
      S_SHIFT: begin
        // Read entry i+1 while entry i-1 is written, so the two never meet.
        if (issue) begin
          rd_en    = 1'b1;
          rvld_nxt = 1'b1;
          cnt_nxt  = cnt_r + CNT_W'(1);
        end
        if (rvld_r) begin
          wr_en   = 1'b1;
          wr_addr = raddr_r - IDX_W'(1);
          wr_data = rd_data;
        end
        if (last) begin
          occ_nxt   = occ_r - CNT_W'(1);
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    res_data.out_value   = res_val_r;
    res_data.status      = res_st_r;
    res_data.entry_count = COUNT_W'(occ_r);
    res_data.is_full     = (occ_r >= cap_eff);
    res_data.is_empty    = (occ_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      occ_r   <= '0;
      rvld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      occ_r   <= occ_nxt;
      rvld_r  <= rvld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r       <= cnt_nxt;
    raddr_r     <= raddr_nxt;
    best_idx_r  <= best_idx_nxt;
    best_prio_r <= best_prio_nxt;
    res_val_r   <= res_val_nxt;
    res_st_r    <= res_st_nxt;
  end

  a_extract_scans: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_data.op == OP_EXTRACT) && (occ_r != '0) |=> state_r == S_SCAN)
    else $error("extract on a non-empty queue did not start a scan");

  a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == S_SHIFT) || (in_acc && (in_data.op == OP_ADD)))
    else $error("entry memory written outside an add or a shift");

  a_count_moves_at_done: assert property (@(posedge clk) disable iff (!rst_n)
    (occ_r != $past(occ_r)) |-> state_r == S_DONE)
    else $error("occupancy changed without finishing an operation");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !res_ready |=> res_valid && $stable(res_data))
    else $error("pending result changed before it was taken");

endmodule

// ===== hdl/priority_queue_linear_scan.sv =====
// Channel  Handshake              Beat contents
// -------  ---------------------  ----------------------------------------------
// in_*     in_valid / in_stall    in_item_t: op, item_value, item_priority
// out_*    out_valid / out_stall  out_item_t: out_value, status, count, flags
// cfg_*    cfg_valid / cfg_ready  capacity_limit, 5 bits
//
// An add or an empty extract goes from acceptance straight to its result state.
// An extract on n entries with its winner at index b scans, then closes the gap, one
// entry per cycle, unless the winner is last; a new beat is accepted only once the
// previous result has gone to the output register.
// Synchronous reset (rst_n low) empties the queue and sets the capacity to 16.
// A stalled result holds the output register; the next beat still runs, then waits.
module priority_queue_linear_scan #(
  parameter int DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  pqls_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output pqls_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [pqls_pkg::CAP_W-1:0] cfg_data
);
  import pqls_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  // Wide enough to compare the 5-bit register against DEPTH without loss.
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  logic [CAP_W-1:0] cap_r;
  logic [CMP_W-1:0] cap_wide;
  logic [CNT_W-1:0] cap_eff;

  logic      res_valid;
  logic      res_ready;
  out_item_t res_data;

  logic      out_valid_r;
  out_item_t out_data_r;

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  entry_t           rd_data;

  // The capacity register takes a write in any cycle; it is meant to change
  // only while no beat is in flight.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cap_r <= cfg_data;
    end
  end

  // A capacity of zero acts as one; anything above DEPTH saturates.
  always_comb begin
    cap_wide = CMP_W'(cap_r);
    priority if (cap_wide == '0) begin
      cap_eff = CNT_W'(1);
    end else if (cap_wide > CMP_W'(DEPTH)) begin
      cap_eff = CNT_W'(DEPTH);
    end else begin
      cap_eff = CNT_W'(cap_wide);
    end
  end

  pqls_ctrl #(
    .DEPTH (DEPTH),
    .IDX_W (IDX_W),
    .CNT_W (CNT_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cap_eff   (cap_eff),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  pqls_mem #(
    .DEPTH (DEPTH),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Output register: a new result may load in the same cycle the old one
  // leaves, so a consumer that does not stall never holds up the queue.
  assign res_ready = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output beat changed");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res_ready |-> !(out_valid_r && out_stall))
    else $error("result loaded over a stalled output beat");

  a_cap_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cap_eff != '0) && (cap_eff <= CNT_W'(DEPTH)))
    else $error("effective capacity out of range");

endmodule
